// ===== rtl/core/deq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue unit
// no dependencies

package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // request kinds
  localparam logic [2:0] KIND_ADD_FRONT = 3'd0;
  localparam logic [2:0] KIND_ADD_REAR  = 3'd1;
  localparam logic [2:0] KIND_REM_FRONT = 3'd2;
  localparam logic [2:0] KIND_REM_REAR  = 3'd3;
  localparam logic [2:0] KIND_LIST      = 3'd4;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_UNDERFLOW = 3'd1,
    STAT_OVERFLOW  = 3'd2,
    STAT_ELEMENT   = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_cmd_t;

  // chain operation issued by the controller
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic rotate;
  } chain_op_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
`timescale 1ns / 1ps
// one storage cell of the queue chain
// depends on deq_pkg

module deq_cell (
  input  logic                      clk,
  input  deq_pkg::cell_cmd_t        cmd,
  input  logic [deq_pkg::DATA_W-1:0] data_prev,
  input  logic [deq_pkg::DATA_W-1:0] data_nxt,
  input  logic [deq_pkg::DATA_W-1:0] load_data,
  output logic [deq_pkg::DATA_W-1:0] data
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_FROM_PREV: data <= data_prev;
      CELL_FROM_NEXT: data <= data_nxt;
      CELL_LOAD:      data <= load_data;
      default:        data <= data;
    endcase
  end

endmodule

// ===== rtl/core/deq_ctrl.sv =====
`timescale 1ns / 1ps
// request sequencer: fill count, listing walk and result registers
// depends on deq_pkg

module deq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0]                 kind,
  input  logic [deq_pkg::DATA_W-1:0] head_data,
  output logic                       busy,
  output deq_pkg::chain_op_t         op,
  output logic [deq_pkg::CNT_W-1:0]  count,
  output logic                       strobe,
  output logic [2:0]                 status,
  output logic [deq_pkg::DATA_W-1:0] element,
  output logic                       last
);
  import deq_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic                 strobe_next;
  status_t              status_next;
  logic [DATA_W-1:0]    element_next;
  logic                 last_next;
  logic                 full, empty, walk_end;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign walk_end = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign busy     = (state == ST_LIST);

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    op           = '0;
    strobe_next  = 1'b0;
    status_next  = STAT_DONE;
    element_next = '0;
    last_next    = 1'b1;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind)
            KIND_ADD_FRONT, KIND_ADD_REAR: begin
              strobe_next = 1'b1;
              if (full) begin
                status_next = STAT_OVERFLOW;
              end else begin
                op.push_front = (kind == KIND_ADD_FRONT);
                op.push_rear  = (kind == KIND_ADD_REAR);
                count_next    = count + CNT_W'(1);
              end
            end
            KIND_REM_FRONT, KIND_REM_REAR: begin
              strobe_next = 1'b1;
              if (empty) begin
                status_next = STAT_UNDERFLOW;
              end else begin
                op.pop_front = (kind == KIND_REM_FRONT);
                count_next   = count - CNT_W'(1);
              end
            end
            KIND_LIST: begin
              if (empty) begin
                strobe_next = 1'b1;
                status_next = STAT_EMPTY;
              end else begin
                state_next = ST_LIST;
                idx_next   = '0;
              end
            end
            default: begin
              // unused kinds give no result
            end
          endcase
        end
      end
      ST_LIST: begin
        // emit the front cell and rotate it to the rear
        op.rotate    = 1'b1;
        strobe_next  = 1'b1;
        status_next  = STAT_ELEMENT;
        element_next = head_data;
        last_next    = walk_end;
        idx_next     = idx + IDX_W'(1);
        if (walk_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    element <= element_next;
    last    <= last_next;
  end

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// top level of the double-ended queue unit: cell chain plus sequencer
// depends on deq_pkg, deq_cell, deq_ctrl

// Bounded deque of up to DEPTH signed 32-bit values. A request is taken on a
// clock edge with start high and busy low. The result of an add or remove
// request is registered at the accepting edge and shown with strobe high for
// the next cycle. Busy stays low for these, so a new request can follow every
// cycle. A listing of N stored values holds busy high while the chain rotates
// one cell per cycle, and gives N results, front first: the first is shown once
// the sequencer has entered its listing state and registered the front value,
// the final one with last set; an empty listing gives one result. The receiver
// cannot stall: every strobed result must be taken in the cycle it is shown.
// There is no clearing pass after reset; values in unused cells never reach
// the outputs.

module double_ended_queue_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] element,
  output logic               last
);
  import deq_pkg::*;

  // cell i holds the element at queue position i, front in cell 0
  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_cmd_t         cell_cmd  [DEPTH];
  logic [DATA_W-1:0] load_data;
  logic [DATA_W-1:0] elem_q;
  logic [CNT_W-1:0]  count;
  chain_op_t         op;

  // during a rotation the rear slot takes the front value; otherwise the
  // request value is loaded
  assign load_data = op.rotate ? cell_data[0] : DATA_W'(value);

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .head_data (cell_data[0]),
    .busy      (busy),
    .op        (op),
    .count     (count),
    .strobe    (strobe),
    .status    (status),
    .element   (elem_q),
    .last      (last)
  );

  assign element = $signed(elem_q);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS      = CNT_W'(i);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(i + 1);

    // per-cell command decode from the chain operation
    always_comb begin
      cell_cmd[i] = CELL_HOLD;
      if (op.push_front) begin
        cell_cmd[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
      end else if (op.push_rear) begin
        if (POS == count) begin
          cell_cmd[i] = CELL_LOAD;
        end
      end else if (op.pop_front) begin
        cell_cmd[i] = CELL_FROM_NEXT;
      end else if (op.rotate) begin
        if (POS_NEXT == count) begin
          cell_cmd[i] = CELL_LOAD;
        end else if (POS_NEXT < count) begin
          cell_cmd[i] = CELL_FROM_NEXT;
        end
      end
    end

    deq_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd[i]),
      .data_prev (cell_data[(i == 0) ? 0 : i - 1]),
      .data_nxt  (cell_data[(i == DEPTH - 1) ? 0 : i + 1]),
      .load_data (load_data),
      .data      (cell_data[i])
    );
  end

endmodule
